@@ hdl/ssr_pkg.sv @@
// ssr_pkg: types, codes and constants shared by the stream sequence reorder block.
// No dependencies; every other file in hdl/ refers to it by scoped names.
`timescale 1ns / 1ps

package ssr_pkg;

  // Field widths fixed by the interface
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned SEQ_W    = 12;
  localparam int unsigned EXP_W    = 13;
  localparam int unsigned TAG_W    = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ACTIVE_W = 4;
  localparam int unsigned QUEUED_W = 7;
  localparam int unsigned DEPTH_W  = 4;

  // Sequence numbers wrap to zero on reaching this value
  localparam logic [EXP_W-1:0] SEQ_WRAP = 13'h0FFF;
  // Expected number of a freshly opened stream: -1, nothing matches yet
  localparam logic [EXP_W-1:0] EXP_NONE = 13'h1FFF;

  // Queue depths of the input and result buffers
  localparam int unsigned FRONT_DEPTH = 2;
  localparam int unsigned RES_DEPTH   = 2;

  // Register file
  localparam logic [3:0] MAX_DEPTH_RESET   = 4'd8;
  localparam logic       REG_IDX_MAX_DEPTH = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_DELIVER    = 3'd0,
    KIND_ACK        = 3'd1,
    KIND_QUEUED     = 3'd2,
    KIND_BYPASS     = 3'd3,
    KIND_TABLE_FULL = 3'd4,
    KIND_QUEUE_FULL = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CLASS,
    ST_INS_RD,
    ST_INS_CMP,
    ST_DRAIN,
    ST_DRN_CHK,
    ST_FIN
  } state_e;

  // One received message, classified by the front end
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] seq;
    logic             start_f;
    logic             end_f;
    logic [TAG_W-1:0] tag;
    logic             tiny;
  } item_t;

  // One held early message
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
    logic             end_f;
  } slot_t;

  // One result transaction
  typedef struct packed {
    kind_e               kind;
    logic [TAG_W-1:0]    tag;
    logic [SEQ_W-1:0]    seq;
    logic                end_f;
    logic                last;
    logic [ACTIVE_W-1:0] active;
    logic [QUEUED_W-1:0] queued;
  } result_t;

  // Number following s, wrapping to zero at SEQ_WRAP
  function automatic logic [EXP_W-1:0] next_seq(logic [SEQ_W-1:0] s);
    logic [EXP_W-1:0] n;
    n = {1'b0, s} + 13'd1;
    return (n >= SEQ_WRAP) ? '0 : n;
  endfunction

endpackage

@@ hdl/ssr_front.sv @@
// ssr_front: input queue of the reorder block; takes messages and tags tiny ones.
// Depends on ssr_pkg.
`timescale 1ns / 1ps

module ssr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [ssr_pkg::KEY_W-1:0]  stream_key_i,
  input  logic [ssr_pkg::SEQ_W-1:0]  seq_num_i,
  input  logic                       start_flag_i,
  input  logic                       end_flag_i,
  input  logic [ssr_pkg::TAG_W-1:0]  msg_tag_i,
  output ssr_pkg::item_t             item_o,
  output logic                       item_valid_o,
  input  logic                       item_ready_i
);

  localparam int unsigned PW = (ssr_pkg::FRONT_DEPTH > 1) ? $clog2(ssr_pkg::FRONT_DEPTH) : 1;
  localparam int unsigned CW = $clog2(ssr_pkg::FRONT_DEPTH + 1);

  ssr_pkg::item_t buf_q [ssr_pkg::FRONT_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;
  ssr_pkg::item_t in_item;

  // Classify: a message with both flags bypasses the stream table
  always_comb begin
    in_item.key     = stream_key_i;
    in_item.seq     = seq_num_i;
    in_item.start_f = start_flag_i;
    in_item.end_f   = end_flag_i;
    in_item.tag     = msg_tag_i;
    in_item.tiny    = start_flag_i & end_flag_i;
  end

  assign full         = (cnt_q == CW'(ssr_pkg::FRONT_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = buf_q[rd_q];
  assign do_push      = push & ~full;
  assign do_pop       = item_valid_o & item_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(ssr_pkg::FRONT_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(ssr_pkg::FRONT_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= in_item;
    end
  end

endmodule

@@ hdl/ssr_res_fifo.sv @@
// ssr_res_fifo: result queue between the reorder engine and the output ports.
// Depends on ssr_pkg.
`timescale 1ns / 1ps

module ssr_res_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssr_pkg::result_t res_i,
  input  logic             res_push_i,
  output logic             res_full_o,
  output ssr_pkg::result_t res_o,
  output logic             empty,
  input  logic             pop
);

  localparam int unsigned PW = (ssr_pkg::RES_DEPTH > 1) ? $clog2(ssr_pkg::RES_DEPTH) : 1;
  localparam int unsigned CW = $clog2(ssr_pkg::RES_DEPTH + 1);

  ssr_pkg::result_t buf_q [ssr_pkg::RES_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign res_full_o = (cnt_q == CW'(ssr_pkg::RES_DEPTH));
  assign empty      = (cnt_q == '0);
  assign res_o      = buf_q[rd_q];
  assign do_push    = res_push_i & ~res_full_o;
  assign do_pop     = pop & ~empty;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(ssr_pkg::RES_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(ssr_pkg::RES_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= res_i;
    end
  end

endmodule

@@ hdl/ssr_engine.sv @@
// ssr_engine: stream table, per-stream sorted ring queues and the sequencer that
// looks up, delivers, queues and drains messages. Depends on ssr_pkg.
`timescale 1ns / 1ps

module ssr_engine #(
  parameter int unsigned NUM_STREAMS = 8,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ssr_pkg::item_t               item_i,
  input  logic                         item_valid_i,
  output logic                         item_ready_o,
  input  logic [ssr_pkg::DEPTH_W-1:0]  max_depth_i,
  output ssr_pkg::result_t             res_o,
  output logic                         res_push_o,
  input  logic                         res_full_i
);

  localparam int unsigned SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = $clog2(2 * QUEUE_DEPTH);
  localparam int unsigned NSLOT = NUM_STREAMS * QUEUE_DEPTH;
  localparam int unsigned AW = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int unsigned TW = $clog2(NSLOT + 1);
  localparam int unsigned NW = $clog2(NUM_STREAMS + 1);
  localparam int unsigned LW = 6;

  ssr_pkg::state_e state_q, state_d;

  // Stream table
  logic [NUM_STREAMS-1:0]        valid_q;
  logic [ssr_pkg::KEY_W-1:0]     id_q   [NUM_STREAMS];
  logic [ssr_pkg::EXP_W-1:0]     exp_q  [NUM_STREAMS];
  logic [CW-1:0]                 cnt_q  [NUM_STREAMS];
  logic [QW-1:0]                 head_q [NUM_STREAMS];
  logic [NW-1:0]                 active_q;
  logic [TW-1:0]                 total_q;

  // Work registers
  ssr_pkg::item_t   item_q;
  logic [SW-1:0]    cur_q, free_q;
  logic             free_f_q;
  logic [CW-1:0]    hole_q;
  ssr_pkg::result_t pend_q;
  logic             pend_v_q;

  // Slot memory
  ssr_pkg::slot_t   mem [NSLOT];
  ssr_pkg::slot_t   rd_q;

  // Derived views of the current stream
  logic [ssr_pkg::EXP_W-1:0] cur_exp, exp_eff, seq_x;
  logic [CW-1:0]             cur_cnt;
  logic [QW-1:0]             cur_head, head_inc;
  logic                      key_hit, last_idx, have_free;
  logic [SW-1:0]             new_free;
  logic                      is_eq, is_lt, q_full, rd_match, rd_later;
  logic [LW-1:0]             limit;

  // Controls from the output decoder
  logic             mem_rd_en, mem_wr_en;
  logic [CW-1:0]    mem_rd_l, mem_wr_l;
  ssr_pkg::slot_t   mem_wr_data;
  logic             pend_load;
  ssr_pkg::result_t pend_d;
  logic             open_new, close_now, ins_done, pop_now, drn_go;

  function automatic logic [AW-1:0] slot_addr(logic [SW-1:0] s, logic [QW-1:0] h,
                                               logic [CW-1:0] l);
    logic [PW-1:0] sum;
    logic [PW-1:0] w;
    sum = PW'(h) + PW'(l);
    w   = (sum >= PW'(QUEUE_DEPTH)) ? sum - PW'(QUEUE_DEPTH) : sum;
    return AW'(int'(s) * QUEUE_DEPTH + int'(w));
  endfunction

  function automatic ssr_pkg::result_t mk_res(ssr_pkg::kind_e k, logic [ssr_pkg::TAG_W-1:0] t,
                                              logic [ssr_pkg::SEQ_W-1:0] s, logic e,
                                              logic [NW-1:0] a, logic [TW-1:0] q);
    ssr_pkg::result_t r;
    r.kind   = k;
    r.tag    = t;
    r.seq    = s;
    r.end_f  = e;
    r.last   = 1'b0;
    r.active = ssr_pkg::ACTIVE_W'(a);
    r.queued = ssr_pkg::QUEUED_W'(q);
    return r;
  endfunction

  assign cur_exp   = exp_q[cur_q];
  assign cur_cnt   = cnt_q[cur_q];
  assign cur_head  = head_q[cur_q];
  assign head_inc  = (cur_head == QW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + QW'(1);
  assign seq_x     = {1'b0, item_q.seq};
  assign exp_eff   = item_q.start_f ? seq_x : cur_exp;
  assign is_eq     = (seq_x == exp_eff);
  assign is_lt     = ($signed(seq_x) < $signed(exp_eff));
  assign limit     = (LW'(max_depth_i) > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : LW'(max_depth_i);
  assign q_full    = (LW'(cur_cnt) >= limit);
  assign key_hit   = valid_q[cur_q] && (id_q[cur_q] == item_q.key);
  assign last_idx  = (cur_q == SW'(NUM_STREAMS - 1));
  assign have_free = free_f_q || !valid_q[cur_q];
  assign new_free  = free_f_q ? free_q : cur_q;
  assign rd_match  = ({1'b0, rd_q.seq} == cur_exp);
  assign rd_later  = (rd_q.seq > item_q.seq);
  assign drn_go    = rd_match && !(pend_v_q && res_full_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssr_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          state_d = item_i.tiny ? ssr_pkg::ST_FIN : ssr_pkg::ST_LOOK;
        end
      end
      ssr_pkg::ST_LOOK: begin
        if (key_hit) begin
          state_d = ssr_pkg::ST_CLASS;
        end else if (last_idx) begin
          state_d = have_free ? ssr_pkg::ST_CLASS : ssr_pkg::ST_FIN;
        end
      end
      ssr_pkg::ST_CLASS: begin
        if (is_eq) begin
          state_d = item_q.end_f ? ssr_pkg::ST_FIN : ssr_pkg::ST_DRAIN;
        end else if (is_lt || q_full) begin
          state_d = ssr_pkg::ST_FIN;
        end else begin
          state_d = ssr_pkg::ST_INS_RD;
        end
      end
      ssr_pkg::ST_INS_RD: begin
        state_d = (hole_q == '0) ? ssr_pkg::ST_DRAIN : ssr_pkg::ST_INS_CMP;
      end
      ssr_pkg::ST_INS_CMP: begin
        state_d = rd_later ? ssr_pkg::ST_INS_RD : ssr_pkg::ST_DRAIN;
      end
      ssr_pkg::ST_DRAIN: begin
        state_d = (cur_cnt != '0) ? ssr_pkg::ST_DRN_CHK : ssr_pkg::ST_FIN;
      end
      ssr_pkg::ST_DRN_CHK: begin
        if (!rd_match) begin
          state_d = ssr_pkg::ST_FIN;
        end else if (drn_go) begin
          state_d = rd_q.end_f ? ssr_pkg::ST_FIN : ssr_pkg::ST_DRAIN;
        end
      end
      ssr_pkg::ST_FIN: begin
        if (!res_full_i) begin
          state_d = ssr_pkg::ST_IDLE;
        end
      end
      default: state_d = ssr_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    item_ready_o = 1'b0;
    res_push_o   = 1'b0;
    res_o        = pend_q;
    res_o.last   = (state_q == ssr_pkg::ST_FIN);
    mem_rd_en    = 1'b0;
    mem_rd_l     = '0;
    mem_wr_en    = 1'b0;
    mem_wr_l     = hole_q;
    mem_wr_data  = '{seq: item_q.seq, tag: item_q.tag, end_f: item_q.end_f};
    pend_load    = 1'b0;
    pend_d       = pend_q;
    open_new     = 1'b0;
    close_now    = 1'b0;
    ins_done     = 1'b0;
    pop_now      = 1'b0;
    unique case (state_q)
      ssr_pkg::ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i && item_i.tiny) begin
          pend_load = 1'b1;
          pend_d    = mk_res(ssr_pkg::KIND_BYPASS, item_i.tag, item_i.seq, 1'b0,
                             active_q, total_q);
        end
      end
      ssr_pkg::ST_LOOK: begin
        if (!key_hit && last_idx) begin
          if (have_free) begin
            open_new = 1'b1;
          end else begin
            pend_load = 1'b1;
            pend_d    = mk_res(ssr_pkg::KIND_TABLE_FULL, item_q.tag, item_q.seq, 1'b0,
                               active_q, total_q);
          end
        end
      end
      ssr_pkg::ST_CLASS: begin
        pend_load = 1'b1;
        if (is_eq) begin
          close_now = item_q.end_f;
          pend_d    = item_q.end_f
                    ? mk_res(ssr_pkg::KIND_DELIVER, item_q.tag, item_q.seq, 1'b1,
                             active_q - NW'(1), total_q - TW'(cur_cnt))
                    : mk_res(ssr_pkg::KIND_DELIVER, item_q.tag, item_q.seq, 1'b0,
                             active_q, total_q);
        end else if (is_lt) begin
          pend_d = mk_res(ssr_pkg::KIND_ACK, item_q.tag, item_q.seq, 1'b0, active_q, total_q);
        end else if (q_full) begin
          pend_d = mk_res(ssr_pkg::KIND_QUEUE_FULL, item_q.tag, item_q.seq, 1'b0,
                          active_q, total_q);
        end else begin
          pend_load = 1'b0;
        end
      end
      ssr_pkg::ST_INS_RD: begin
        if (hole_q == '0) begin
          mem_wr_en = 1'b1;
          ins_done  = 1'b1;
        end else begin
          mem_rd_en = 1'b1;
          mem_rd_l  = hole_q - CW'(1);
        end
      end
      ssr_pkg::ST_INS_CMP: begin
        mem_wr_en = 1'b1;
        if (rd_later) begin
          mem_wr_data = rd_q;
        end else begin
          ins_done = 1'b1;
        end
      end
      ssr_pkg::ST_DRAIN: begin
        mem_rd_en = (cur_cnt != '0);
      end
      ssr_pkg::ST_DRN_CHK: begin
        if (drn_go) begin
          pop_now    = 1'b1;
          close_now  = rd_q.end_f;
          res_push_o = pend_v_q;
          pend_load  = 1'b1;
          pend_d     = rd_q.end_f
                     ? mk_res(ssr_pkg::KIND_DELIVER, rd_q.tag, rd_q.seq, 1'b1,
                              active_q - NW'(1), total_q - TW'(cur_cnt))
                     : mk_res(ssr_pkg::KIND_DELIVER, rd_q.tag, rd_q.seq, 1'b0,
                              active_q, total_q - TW'(1));
        end
      end
      ssr_pkg::ST_FIN: begin
        res_push_o = !res_full_i;
      end
      default: ;
    endcase
    if (ins_done) begin
      pend_load = 1'b1;
      pend_d    = mk_res(ssr_pkg::KIND_QUEUED, item_q.tag, item_q.seq, 1'b0,
                         active_q, total_q + TW'(1));
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ssr_pkg::ST_IDLE;
      valid_q  <= '0;
      active_q <= '0;
      total_q  <= '0;
      cur_q    <= '0;
      free_q   <= '0;
      free_f_q <= 1'b0;
      pend_v_q <= 1'b0;
      for (int i = 0; i < NUM_STREAMS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (pend_load) begin
        pend_v_q <= 1'b1;
      end else if (state_q == ssr_pkg::ST_FIN && !res_full_i) begin
        pend_v_q <= 1'b0;
      end
      // Table scan, one entry a cycle
      if (state_q == ssr_pkg::ST_IDLE) begin
        cur_q    <= '0;
        free_f_q <= 1'b0;
      end else if (state_q == ssr_pkg::ST_LOOK && !key_hit) begin
        if (last_idx) begin
          cur_q <= new_free;
        end else begin
          if (!valid_q[cur_q] && !free_f_q) begin
            free_q   <= cur_q;
            free_f_q <= 1'b1;
          end
          cur_q <= cur_q + SW'(1);
        end
      end
      if (open_new) begin
        valid_q[new_free] <= 1'b1;
        cnt_q[new_free]   <= '0;
        active_q          <= active_q + NW'(1);
      end
      if (close_now) begin
        valid_q[cur_q] <= 1'b0;
        cnt_q[cur_q]   <= '0;
        active_q       <= active_q - NW'(1);
        total_q        <= total_q - TW'(cur_cnt);
      end else if (pop_now) begin
        cnt_q[cur_q] <= cur_cnt - CW'(1);
        total_q      <= total_q - TW'(1);
      end else if (ins_done) begin
        cnt_q[cur_q] <= cur_cnt + CW'(1);
        total_q      <= total_q + TW'(1);
      end
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      item_q <= item_i;
    end
    if (pend_load) begin
      pend_q <= pend_d;
    end
    if (open_new) begin
      id_q[new_free]   <= item_q.key;
      exp_q[new_free]  <= ssr_pkg::EXP_NONE;
      head_q[new_free] <= '0;
    end
    if (state_q == ssr_pkg::ST_CLASS) begin
      if (is_eq) begin
        exp_q[cur_q] <= ssr_pkg::next_seq(item_q.seq);
      end else if (item_q.start_f) begin
        exp_q[cur_q] <= seq_x;
      end
      hole_q <= cur_cnt;
    end else if (state_q == ssr_pkg::ST_INS_CMP && rd_later) begin
      hole_q <= hole_q - CW'(1);
    end
    if (pop_now) begin
      exp_q[cur_q]  <= ssr_pkg::next_seq(rd_q.seq);
      head_q[cur_q] <= head_inc;
    end
  end

  // Slot memory: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      mem[slot_addr(cur_q, cur_head, mem_wr_l)] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_q <= mem[slot_addr(cur_q, cur_head, mem_rd_l)];
    end
  end

endmodule

@@ hdl/stream_sequence_reorder.sv @@
// stream_sequence_reorder: top level with the configuration register and the
// front queue, reorder engine and result queue. Depends on ssr_pkg and all ssr_* modules.
`timescale 1ns / 1ps

// Reorders received messages per stream by sequence number. Each message yields one
// to QUEUE_DEPTH+1 result transactions ending with last=1: a delivery (plus any held
// messages it releases), a repeat ack, a queued notice, a tiny bypass, or a table/queue
// full reject. A message passes through an accept step, the stream table scan (it stops
// at the matching entry), a classify step, a read and a compare per held message shifted
// on a sorted insert, a read and a check per released message, a check that the queue
// head does not match, and a closing step, plus any wait on a full result queue. Tiny
// messages go from the accept step straight to the closing step. Messages are taken one
// at a time; a two-entry queue on each side keeps push and pop independent of the engine.
// max_queue_depth (address 0) must be written only while idle; the block itself does not
// enforce this. No clearing pass is needed after reset.
module stream_sequence_reorder #(
  parameter int unsigned NUM_STREAMS = 8,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [15:0] stream_key_i,
  input  logic [11:0] seq_num_i,
  input  logic        start_flag_i,
  input  logic        end_flag_i,
  input  logic [7:0]  msg_tag_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [7:0]  out_tag_o,
  output logic [11:0] out_seq_o,
  output logic        out_end_o,
  output logic        last_o,
  output logic [3:0]  streams_active_o,
  output logic [6:0]  msgs_queued_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ssr_pkg::DEPTH_W-1:0] max_depth_q;
  logic                        reg_sel;
  ssr_pkg::item_t              item;
  logic                        item_valid, item_ready;
  ssr_pkg::result_t            eng_res, out_res;
  logic                        res_push, res_full;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == ssr_pkg::REG_IDX_MAX_DEPTH);
  assign prdata  = reg_sel ? {28'd0, max_depth_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_depth_q <= ssr_pkg::MAX_DEPTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_depth_q <= pwdata[ssr_pkg::DEPTH_W-1:0];
    end
  end

  ssr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .stream_key_i (stream_key_i),
    .seq_num_i    (seq_num_i),
    .start_flag_i (start_flag_i),
    .end_flag_i   (end_flag_i),
    .msg_tag_i    (msg_tag_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  ssr_engine #(
    .NUM_STREAMS (NUM_STREAMS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .max_depth_i  (max_depth_q),
    .res_o        (eng_res),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  ssr_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (eng_res),
    .res_push_i (res_push),
    .res_full_o (res_full),
    .res_o      (out_res),
    .empty      (empty),
    .pop        (pop)
  );

  // Result fields
  assign kind_o           = out_res.kind;
  assign out_tag_o        = out_res.tag;
  assign out_seq_o        = out_res.seq;
  assign out_end_o        = out_res.end_f;
  assign last_o           = out_res.last;
  assign streams_active_o = out_res.active;
  assign msgs_queued_o    = out_res.queued;

endmodule

@@ bench/ssr_reorder_checker.sv @@
// ssr_reorder_checker: watches the message, result and register channels of
// stream_sequence_reorder, predicts every result and compares. Depends on ssr_pkg.
`timescale 1ns / 1ps

module ssr_reorder_checker
  import ssr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [15:0] stream_key_i,
  input  logic [11:0] seq_num_i,
  input  logic        start_flag_i,
  input  logic        end_flag_i,
  input  logic [7:0]  msg_tag_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  kind_o,
  input  logic [7:0]  out_tag_o,
  input  logic [11:0] out_seq_o,
  input  logic        out_end_o,
  input  logic        last_o,
  input  logic [3:0]  streams_active_o,
  input  logic [6:0]  msgs_queued_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_count
);

  localparam int NS = 8;
  localparam int QD = 8;

  // Shadow of the stream table and held messages
  bit              open_q [NS];
  logic [15:0]     key_q  [NS];
  int              want_q [NS];   // expected number, -1 when none yet
  int              held_q [NS];
  logic [11:0]     hseq_q [NS][QD];
  logic [7:0]      htag_q [NS][QD];
  logic            hend_q [NS][QD];
  int              held_total;
  int              depth_reg;

  result_t         pending_results[$];

  function automatic int seq_after(int s);
    int n;
    n = s + 1;
    return (n >= int'(SEQ_WRAP)) ? 0 : n;
  endfunction

  task automatic note_result(kind_e k, logic [7:0] tag, logic [11:0] seq, logic e);
    result_t r;
    int act;
    act = 0;
    for (int i = 0; i < NS; i++) act += open_q[i];
    r.kind   = k;
    r.tag    = tag;
    r.seq    = seq;
    r.end_f  = e;
    r.last   = 1'b0;
    r.active = ACTIVE_W'(act);
    r.queued = QUEUED_W'(held_total);
    pending_results.push_back(r);
  endtask

  task automatic close_stream(int s);
    open_q[s] = 1'b0;
    held_total -= held_q[s];
    held_q[s] = 0;
  endtask

  // Release held messages that now match the expected number
  task automatic release_held(int s);
    logic [11:0] sq;
    logic [7:0]  tg;
    logic        en;
    while (open_q[s] && held_q[s] > 0) begin
      sq = hseq_q[s][0];
      tg = htag_q[s][0];
      en = hend_q[s][0];
      if (int'(sq) != want_q[s]) break;
      for (int i = 0; i < held_q[s] - 1; i++) begin
        hseq_q[s][i] = hseq_q[s][i+1];
        htag_q[s][i] = htag_q[s][i+1];
        hend_q[s][i] = hend_q[s][i+1];
      end
      held_q[s]--;
      held_total--;
      want_q[s] = seq_after(sq);
      if (en) close_stream(s);
      note_result(KIND_DELIVER, tg, sq, en);
      if (en) break;
    end
  endtask

  // Predict the results of one accepted message
  task automatic reorder_message(logic [15:0] key, logic [11:0] seq, logic st,
                                 logic en, logic [7:0] tag);
    int s, pos, lim;
    bit found;
    found = 1'b0;
    s = 0;
    if (st && en) begin
      note_result(KIND_BYPASS, tag, seq, 1'b0);
      pending_results[$].last = 1'b1;
      return;
    end
    for (int i = 0; i < NS && !found; i++)
      if (open_q[i] && key_q[i] == key) begin
        found = 1'b1;
        s = i;
      end
    if (!found) begin
      for (int i = 0; i < NS && !found; i++)
        if (!open_q[i]) begin
          found = 1'b1;
          s = i;
        end
      if (!found) begin
        note_result(KIND_TABLE_FULL, tag, seq, 1'b0);
        pending_results[$].last = 1'b1;
        return;
      end
      open_q[s] = 1'b1;
      key_q[s]  = key;
      want_q[s] = -1;
      held_q[s] = 0;
    end
    if (st) want_q[s] = int'(seq);
    if (int'(seq) == want_q[s]) begin
      want_q[s] = seq_after(seq);
      if (en) close_stream(s);
      note_result(KIND_DELIVER, tag, seq, en);
      if (!en) release_held(s);
    end else if (int'(seq) < want_q[s]) begin
      note_result(KIND_ACK, tag, seq, 1'b0);
    end else begin
      lim = (depth_reg < QD) ? depth_reg : QD;
      if (held_q[s] >= lim) begin
        note_result(KIND_QUEUE_FULL, tag, seq, 1'b0);
      end else begin
        pos = held_q[s];
        for (int i = held_q[s] - 1; i >= 0; i--)
          if (hseq_q[s][i] > seq) pos = i;
        for (int i = held_q[s]; i > pos; i--) begin
          hseq_q[s][i] = hseq_q[s][i-1];
          htag_q[s][i] = htag_q[s][i-1];
          hend_q[s][i] = hend_q[s][i-1];
        end
        hseq_q[s][pos] = seq;
        htag_q[s][pos] = tag;
        hend_q[s][pos] = en;
        held_q[s]++;
        held_total++;
        note_result(KIND_QUEUED, tag, seq, 1'b0);
        release_held(s);
      end
    end
    pending_results[$].last = 1'b1;
  endtask

  // Compare one accepted result transaction with the oldest prediction
  task automatic check_result();
    result_t got, want;
    got.kind   = kind_e'(kind_o);
    got.tag    = out_tag_o;
    got.seq    = out_seq_o;
    got.end_f  = out_end_o;
    got.last   = last_o;
    got.active = streams_active_o;
    got.queued = msgs_queued_o;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: kind %0d tag %0d seq %0d", got.kind, got.tag, got.seq);
      return;
    end
    want = pending_results.pop_front();
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch: expected kind %0d tag %0d seq %0d end %0b last %0b act %0d q %0d, got kind %0d tag %0d seq %0d end %0b last %0b act %0d q %0d",
                 want.kind, want.tag, want.seq, want.end_f, want.last, want.active,
                 want.queued, got.kind, got.tag, got.seq, got.end_f, got.last,
                 got.active, got.queued);
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) begin
        open_q[i] = 1'b0;
        held_q[i] = 0;
      end
      held_total = 0;
      depth_reg = int'(MAX_DEPTH_RESET);
      pending_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_IDX_MAX_DEPTH, 2'b00})
        depth_reg = int'(pwdata[3:0]);
      if (pop && !empty) check_result();
      if (push && !full)
        reorder_message(stream_key_i, seq_num_i, start_flag_i, end_flag_i, msg_tag_i);
    end
    pending_count = pending_results.size();
  end

endmodule

@@ bench/stream_sequence_reorder_test.sv @@
// stream_sequence_reorder_test: drives messages, result pops and register writes
// into stream_sequence_reorder and gives the verdict. Depends on ssr_pkg and ssr_reorder_checker.
`timescale 1ns / 1ps

module stream_sequence_reorder_test;
  import ssr_pkg::*;

  typedef struct {
    logic [15:0] key;
    int          next;
  } open_stream_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] stream_key_i = '0;
  logic [11:0] seq_num_i = '0;
  logic        start_flag_i = 1'b0;
  logic        end_flag_i = 1'b0;
  logic [7:0]  msg_tag_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  out_tag_o;
  logic [11:0] out_seq_o;
  logic        out_end_o;
  logic        last_o;
  logic [3:0]  streams_active_o;
  logic [6:0]  msgs_queued_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int           fail_count;
  int           pending_count;
  bit           quiet = 1'b0;
  int           sent = 0;
  int           depth_lim = 8;
  int           pop_gap = 0;
  int           stall_cycles = 0;
  open_stream_t open_streams[$];

  stream_sequence_reorder dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full),
    .stream_key_i(stream_key_i), .seq_num_i(seq_num_i), .start_flag_i(start_flag_i),
    .end_flag_i(end_flag_i), .msg_tag_i(msg_tag_i),
    .empty(empty), .pop(pop),
    .kind_o(kind_o), .out_tag_o(out_tag_o), .out_seq_o(out_seq_o), .out_end_o(out_end_o),
    .last_o(last_o), .streams_active_o(streams_active_o), .msgs_queued_o(msgs_queued_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  ssr_reorder_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full),
    .stream_key_i(stream_key_i), .seq_num_i(seq_num_i), .start_flag_i(start_flag_i),
    .end_flag_i(end_flag_i), .msg_tag_i(msg_tag_i),
    .empty(empty), .pop(pop),
    .kind_o(kind_o), .out_tag_o(out_tag_o), .out_seq_o(out_seq_o), .out_end_o(out_end_o),
    .last_o(last_o), .streams_active_o(streams_active_o), .msgs_queued_o(msgs_queued_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Result side: pop with random stall bursts
  always @(posedge clk_i) begin
    if (pop_gap > 0) begin
      pop <= 1'b0;
      pop_gap--;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      pop <= 1'b0;
      pop_gap = $urandom_range(1, 11) - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog: cycles without any accepted transaction
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (psel && penable))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= 3000) begin
      $display("FAIL stream_sequence_reorder");
      $finish;
    end
  end

  function automatic int seq_after(int s);
    int n;
    n = s + 1;
    return (n >= int'(SEQ_WRAP)) ? 0 : n;
  endfunction

  task automatic send_msg(logic [15:0] key, int seq, bit st, bit en, logic [7:0] tag);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    push         <= 1'b1;
    stream_key_i <= key;
    seq_num_i    <= 12'(seq);
    start_flag_i <= st;
    end_flag_i   <= en;
    msg_tag_i    <= tag;
    do @(posedge clk_i); while (full);
    sent++;
  endtask

  // Hold off until every predicted result has been popped and the engine is done
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  task automatic set_depth(int v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_IDX_MAX_DEPTH, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    depth_lim = (v < 8) ? v : 8;
  endtask

  function automatic logic [15:0] fresh_key();
    logic [15:0] k;
    bit clash;
    do begin
      k = 16'($urandom);
      clash = 1'b0;
      foreach (open_streams[i]) if (open_streams[i].key == k) clash = 1'b1;
    end while (clash);
    return k;
  endfunction

  // One stream sent in reversed blocks small enough to fit the held-message limit
  task automatic run_stream(int len, bit keep_open);
    logic [15:0] key;
    int seqs[16];
    int i, b, cap, idx;
    bit rejected;
    key = fresh_key();
    rejected = open_streams.size() >= 8;
    seqs[0] = ($urandom_range(0, 9) == 0) ? $urandom_range(4085, 4095) : $urandom_range(0, 4094);
    for (int k = 1; k < len; k++) seqs[k] = seq_after(seqs[k-1]);
    i = 0;
    while (i < len) begin
      cap = depth_lim + 1;
      if (cap > len - i) cap = len - i;
      b = $urandom_range(1, cap);
      if (seqs[i+b-1] < seqs[i]) b = 1;
      for (int j = b - 1; j >= 0; j--) begin
        idx = i + j;
        send_msg(key, seqs[idx], idx == 0, idx == len - 1 && !keep_open, 8'($urandom));
      end
      i += b;
      // repeat of an already delivered message
      if (i < len && seqs[i] != 0 && $urandom_range(0, 11) == 0)
        send_msg(key, seqs[i-1], 1'b0, 1'b0, 8'($urandom));
    end
    if (keep_open && !rejected) open_streams.push_back('{key, seq_after(seqs[len-1])});
  endtask

  task automatic close_oldest();
    open_stream_t o;
    o = open_streams.pop_front();
    send_msg(o.key, o.next, 1'b0, 1'b1, 8'($urandom));
  endtask

  // Stray traffic: tiny messages, early and old numbers, streams left open
  task automatic send_noise();
    int r, s, pick;
    logic [15:0] k;
    r = $urandom_range(0, 3);
    if (r == 1 && open_streams.size() > 0) begin
      pick = $urandom_range(0, open_streams.size() - 1);
      s = open_streams[pick].next;
      repeat ($urandom_range(1, 4)) s = seq_after(s);
      send_msg(open_streams[pick].key, s, 1'b0, 1'b0, 8'($urandom));
    end else if (r == 2 && open_streams.size() > 0) begin
      pick = $urandom_range(0, open_streams.size() - 1);
      s = open_streams[pick].next;
      if (s > 0) send_msg(open_streams[pick].key, s - 1, 1'b0, 1'b0, 8'($urandom));
      else send_msg(16'($urandom), $urandom_range(0, 4095), 1'b1, 1'b1, 8'($urandom));
    end else if (r == 3 && open_streams.size() < 7) begin
      k = fresh_key();
      s = $urandom_range(0, 4094);
      send_msg(k, s, 1'b1, 1'b0, 8'($urandom));
      open_streams.push_back('{k, seq_after(s)});
    end else begin
      send_msg(16'($urandom), $urandom_range(0, 4095), 1'b1, 1'b1, 8'($urandom));
    end
  endtask

  initial begin
    int depths[6];
    int phase_end, r;
    depths = '{0, 15, 3, 1, 8, 2};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tiny extremes
    send_msg(16'hFFFF, 4095, 1'b1, 1'b1, 8'hFF);
    send_msg(16'h0000, 0, 1'b1, 1'b1, 8'h00);
    // Opened without a start flag: held, then released by the start message
    send_msg(16'h0001, 5, 1'b0, 1'b0, 8'h11);
    send_msg(16'h0001, 4, 1'b1, 1'b0, 8'h12);
    send_msg(16'h0001, 3, 1'b0, 1'b0, 8'h13);
    send_msg(16'h0001, 6, 1'b0, 1'b1, 8'h14);
    // Wrap of the sequence number
    send_msg(16'h8000, 4094, 1'b1, 1'b0, 8'h21);
    send_msg(16'h8000, 0, 1'b0, 1'b1, 8'h22);
    send_msg(16'h8001, 4095, 1'b1, 1'b0, 8'h23);
    send_msg(16'h8001, 0, 1'b0, 1'b1, 8'h24);
    // Full queue released by one message, end in the release
    for (int i = 101; i <= 108; i++)
      send_msg(16'h00AA, i, 1'b0, i == 108, 8'(i));
    send_msg(16'h00AA, 100, 1'b1, 1'b0, 8'hA0);
    // Duplicate held numbers, then a direct end delivery drops them
    send_msg(16'h5555, 10, 1'b1, 1'b0, 8'h31);
    send_msg(16'h5555, 12, 1'b0, 1'b0, 8'h32);
    send_msg(16'h5555, 12, 1'b0, 1'b0, 8'h33);
    send_msg(16'h5555, 11, 1'b0, 1'b1, 8'h34);

    // Random phases, each under a new depth setting
    foreach (depths[p]) begin
      wait_drained();
      if (p == 5) quiet = 1'b1;
      set_depth(depths[p]);
      phase_end = sent + 75;
      while (sent < phase_end) begin
        r = $urandom_range(0, 19);
        if (open_streams.size() >= 8 && $urandom_range(0, 9) < 7)
          close_oldest();
        else if (r < 12)
          run_stream($urandom_range(1, 12), $urandom_range(0, 4) == 0);
        else if (r < 17)
          send_noise();
        else if (open_streams.size() > 0)
          close_oldest();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("PASS stream_sequence_reorder");
    else
      $display("FAIL stream_sequence_reorder");
    $finish;
  end

endmodule
